FILE: hdl/vpd_pkg.sv
// ----------------------------------------------------------------------------
// vpd_pkg
// Types and constants shared by the video packet deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package vpd_pkg;

  localparam int WORD_W = 16;
  localparam int ROW_W  = 6;
  localparam int COL_W  = 7;
  localparam int SKIP_W = 7;
  localparam int CFG_W  = 7;
  localparam int IDX_W  = 1;

  localparam logic [ROW_W-1:0]  ROWS_RESET   = 6'd45;
  localparam logic [SKIP_W-1:0] SKIP_RESET   = 7'd61;
  localparam logic [WORD_W-1:0] DISCARD_MASK = 16'h0f00;

  // register indexes of the configuration port
  localparam logic [IDX_W-1:0] CFG_ROWS_PER_FRAME = 1'b0;
  localparam logic [IDX_W-1:0] CFG_DISCARD_SKIP   = 1'b1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef enum logic [1:0] {
    PH_ID   = 2'd0,
    PH_SKIP = 2'd1,
    PH_CRC  = 2'd2,
    PH_PIX  = 2'd3
  } phase_t;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] value;
    logic [ROW_W-1:0]  row_index;
    logic [COL_W-1:0]  col_index;
    logic              frame_last;
  } result_t;

  // step output toward the result register
  typedef struct packed {
    logic    valid;
    result_t res;
  } step_out_t;

endpackage

`default_nettype wire

FILE: hdl/vpd_if.sv
// ----------------------------------------------------------------------------
// vpd_if
// Valid/ready channels for the input words and the result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface vpd_word_if;
  logic                       valid;
  logic                       ready;
  logic [vpd_pkg::WORD_W-1:0] word_in;

  modport source (output valid, output word_in, input ready);
  modport sink   (input valid, input word_in, output ready);
endinterface

interface vpd_result_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [vpd_pkg::WORD_W-1:0] value;
  logic [vpd_pkg::ROW_W-1:0]  row_index;
  logic [vpd_pkg::COL_W-1:0]  col_index;
  logic                       frame_last;

  modport source (output valid, output kind, output value, output row_index,
                  output col_index, output frame_last, input ready);
  modport sink   (input valid, input kind, input value, input row_index,
                  input col_index, input frame_last, output ready);
endinterface

`default_nettype wire

FILE: hdl/video_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// video_packet_deframer_top
// Splits a camera video word stream into pixel results with row and column, and error results.
// ----------------------------------------------------------------------------
// registers: an accepted input word is held in the input register, decoded by the
//   step logic, and its result is held in the result register until it is taken
// throughput: one word per cycle while the output is ready; a waiting result
//   holds the step, and the input stalls once the input register holds a word
// reset: synchronous, clears phase and counters, loads 45 rows and 61 skip words
`default_nettype none

module video_packet_deframer_top #(
  parameter int PIXELS_PER_ROW = 80
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  vpd_word_if.sink                        in,
  vpd_result_if.source                    out,
  input  wire logic                       cfg_we,
  input  wire logic [vpd_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [vpd_pkg::CFG_W-1:0]  cfg_data
);

  logic                       word_valid;
  logic [vpd_pkg::WORD_W-1:0] word;
  logic                       can_take;
  logic                       advance;
  vpd_pkg::step_out_t         step_out;

  // held word moves on when the result register has room
  assign advance = word_valid && can_take;

  vpd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in         (in),
    .advance    (advance),
    .word_valid (word_valid),
    .word       (word)
  );

  vpd_step #(
    .PIXELS_PER_ROW (PIXELS_PER_ROW)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .word      (word),
    .step_out  (step_out)
  );

  vpd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .step_out (step_out),
    .can_take (can_take),
    .out      (out)
  );

endmodule

`default_nettype wire

FILE: hdl/vpd_in_stage.sv
// ----------------------------------------------------------------------------
// vpd_in_stage
// Input register: holds one received word until the step logic takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module vpd_in_stage (
  input  wire logic                       clk,
  input  wire logic                       rst,
  vpd_word_if.sink                        in,
  input  wire logic                       advance,
  output logic                            word_valid,
  output logic [vpd_pkg::WORD_W-1:0]      word
);

  logic                       valid_q;
  logic [vpd_pkg::WORD_W-1:0] word_q;

  // take a new word when empty or when the held word moves on this cycle
  assign in.ready   = !valid_q || advance;
  assign word_valid = valid_q;
  assign word       = word_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in.ready) begin
      valid_q <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in.ready && in.valid) begin
      word_q <= in.word_in;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/vpd_step.sv
// ----------------------------------------------------------------------------
// vpd_step
// Deframer state, configuration registers and the per-word decode.
// ----------------------------------------------------------------------------
`default_nettype none

module vpd_step #(
  parameter int PIXELS_PER_ROW = 80
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [vpd_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [vpd_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                       advance,
  input  wire logic [vpd_pkg::WORD_W-1:0] word,
  output vpd_pkg::step_out_t              step_out
);

  localparam logic [vpd_pkg::COL_W:0] PIX_LAST = (vpd_pkg::COL_W + 1)'(PIXELS_PER_ROW);

  logic [vpd_pkg::ROW_W-1:0]  rows_per_frame;
  logic [vpd_pkg::SKIP_W-1:0] discard_skip_words;

  vpd_pkg::phase_t            phase, phase_next;
  logic [vpd_pkg::ROW_W-1:0]  row_count, row_count_next;
  logic [vpd_pkg::COL_W-1:0]  col_count, col_count_next;
  logic [vpd_pkg::SKIP_W-1:0] skip_count, skip_count_next;

  logic                       is_discard;
  logic                       id_match;
  logic                       last_col;
  logic                       last_row;
  logic [vpd_pkg::ROW_W-1:0]  eff_rows;
  logic [vpd_pkg::SKIP_W-1:0] skip_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_per_frame     <= vpd_pkg::ROWS_RESET;
      discard_skip_words <= vpd_pkg::SKIP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        vpd_pkg::CFG_ROWS_PER_FRAME: rows_per_frame <= cfg_data[vpd_pkg::ROW_W-1:0];
        vpd_pkg::CFG_DISCARD_SKIP:   discard_skip_words <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero rows acts as one
  assign eff_rows   = (rows_per_frame == '0) ? vpd_pkg::ROW_W'(1) : rows_per_frame;
  assign is_discard = (row_count == '0) &&
                      ((word & vpd_pkg::DISCARD_MASK) == vpd_pkg::DISCARD_MASK);
  assign id_match   = (word[11:0] == 12'(row_count));
  assign last_col   = ({1'b0, col_count} + 1'b1) >= PIX_LAST;
  assign last_row   = ({1'b0, row_count} + 1'b1) >= {1'b0, eff_rows};
  assign skip_dec   = (skip_count != '0) ? skip_count - 1'b1 : skip_count;

  // next state
  always_comb begin
    phase_next      = phase;
    row_count_next  = row_count;
    col_count_next  = col_count;
    skip_count_next = skip_count;
    case (phase)
      vpd_pkg::PH_ID: begin
        if (is_discard) begin
          skip_count_next = discard_skip_words;
          phase_next      = (discard_skip_words == '0) ? vpd_pkg::PH_ID : vpd_pkg::PH_SKIP;
        end else if (id_match) begin
          col_count_next = '0;
          phase_next     = vpd_pkg::PH_CRC;
        end else begin
          row_count_next = '0;
          col_count_next = '0;
          phase_next     = vpd_pkg::PH_ID;
        end
      end
      vpd_pkg::PH_SKIP: begin
        skip_count_next = skip_dec;
        if (skip_dec == '0) begin
          phase_next = vpd_pkg::PH_ID;
        end
      end
      vpd_pkg::PH_CRC: begin
        phase_next = vpd_pkg::PH_PIX;
      end
      vpd_pkg::PH_PIX: begin
        if (last_col) begin
          col_count_next = '0;
          row_count_next = last_row ? '0 : row_count + 1'b1;
          phase_next     = vpd_pkg::PH_ID;
        end else begin
          col_count_next = col_count + 1'b1;
        end
      end
      default: phase_next = vpd_pkg::PH_ID;
    endcase
  end

  // result of the word
  always_comb begin
    step_out.valid          = 1'b0;
    step_out.res.kind       = vpd_pkg::KIND_PIXEL;
    step_out.res.value      = word;
    step_out.res.row_index  = row_count;
    step_out.res.col_index  = '0;
    step_out.res.frame_last = 1'b0;
    case (phase)
      vpd_pkg::PH_ID: begin
        if (!is_discard && !id_match) begin
          step_out.valid    = advance;
          step_out.res.kind = vpd_pkg::KIND_ERROR;
        end
      end
      vpd_pkg::PH_PIX: begin
        step_out.valid          = advance;
        step_out.res.col_index  = col_count;
        step_out.res.frame_last = last_col && last_row;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= vpd_pkg::PH_ID;
      row_count  <= '0;
      col_count  <= '0;
      skip_count <= '0;
    end else if (advance) begin
      phase      <= phase_next;
      row_count  <= row_count_next;
      col_count  <= col_count_next;
      skip_count <= skip_count_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/vpd_out_stage.sv
// ----------------------------------------------------------------------------
// vpd_out_stage
// Result register driving the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module vpd_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 advance,
  input  wire vpd_pkg::step_out_t   step_out,
  output logic                      can_take,
  vpd_result_if.source              out
);

  logic             valid_q;
  vpd_pkg::result_t res_q;

  assign can_take = !valid_q || out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= step_out.valid;
    end else if (out.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_out.valid) begin
      res_q <= step_out.res;
    end
  end

  assign out.valid      = valid_q;
  assign out.kind       = res_q.kind;
  assign out.value      = res_q.value;
  assign out.row_index  = res_q.row_index;
  assign out.col_index  = res_q.col_index;
  assign out.frame_last = res_q.frame_last;

endmodule

`default_nettype wire
